// ===== rtl/icmp_er_pkg.sv =====
// Shared types, codes and checksum helpers for the ICMP echo responder.
package icmp_er_pkg;

  localparam int unsigned HDR_WORDS   = 5;
  localparam int unsigned HDR_IDX_W   = 3;
  localparam int unsigned QUEUE_DEPTH = 8;

  localparam logic [HDR_IDX_W-1:0] HDR_LAST_IDX = 3'd4;

  localparam logic [1:0] MODE_COLLECT = 2'd0;
  localparam logic [1:0] MODE_FORWARD = 2'd1;
  localparam logic [1:0] MODE_DROP    = 2'd2;

  localparam logic [7:0] TTL_RESET         = 8'h40;
  localparam logic [7:0] ALL_BYTES         = 8'hFF;
  localparam logic [7:0] IP_PROTO_ICMP     = 8'h01;
  localparam logic [7:0] ICMP_ECHO_REQUEST = 8'h08;
  localparam logic [7:0] ICMP_ECHO_REPLY   = 8'h00;
  localparam logic [7:0] ICMP_CODE_ECHO    = 8'h00;

  typedef struct packed {
    logic        is_hdr;
    logic [63:0] data;
    logic [7:0]  be;
    logic        last;
  } q_entry_t;

  typedef struct packed {
    logic                           load;
    logic [HDR_WORDS-1:0][63:0]     data;
    logic [HDR_WORDS-1:0][7:0]      be;
  } bank_load_t;

  function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    logic [16:0] t;
    s = {1'b0, a} + {1'b0, b};
    t = {1'b0, s[15:0]} + {16'd0, s[16]};
    return t[15:0];
  endfunction

  // Incremental checksum update: HC' = ~(~HC + ~m + m').
  function automatic logic [15:0] csum_update(input logic [15:0] hc,
                                              input logic [15:0] old_w,
                                              input logic [15:0] new_w);
    logic [15:0] x;
    x = oc_add(~hc, ~old_w);
    x = oc_add(x, new_w);
    return ~x;
  endfunction

endpackage

// ===== rtl/icmp_er_fifo.sv =====
// Small register queue between the classifying front and the output back end.
module icmp_er_fifo import icmp_er_pkg::*; #(
  parameter int unsigned Depth = QUEUE_DEPTH
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  q_entry_t push_entry,
  output logic     full,
  input  logic     pop,
  output q_entry_t head,
  output logic     empty
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  q_entry_t        mem [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign full  = (count == CntFull);
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrLast) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrLast) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/icmp_er_front.sv =====
// Front end: takes frame words, holds the header and builds the echo reply header.
module icmp_er_front import icmp_er_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        frame_valid,
  output logic        frame_stall,
  input  logic [63:0] frame_data,
  input  logic [7:0]  byte_enable,
  input  logic        last_word,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  reply_ttl,
  output logic        q_push,
  output q_entry_t    q_entry,
  input  logic        q_full,
  output bank_load_t  bank_load,
  input  logic        bank_busy
);

  logic [1:0]           mode;
  logic [1:0]           mode_next;
  logic [HDR_IDX_W-1:0] pos;
  logic [HDR_IDX_W-1:0] pos_next;
  logic [HDR_IDX_W-1:0] pos_eff;
  logic [63:0]          hdr_words [4];
  logic [7:0]           hdr_be1;
  logic [7:0]           hdr_be2;
  logic [7:0]           ttl;
  logic                 collecting;
  logic                 hdr_done;
  logic                 accept;
  logic                 is_echo;

  assign cfg_ready  = 1'b1;
  assign pos_eff    = (pos > HDR_LAST_IDX) ? '0 : pos;
  assign collecting = (mode != MODE_FORWARD) && (mode != MODE_DROP);
  assign hdr_done   = collecting && (pos_eff == HDR_LAST_IDX);

  // The fifth header word needs the reply bank free and a queue slot.
  assign frame_stall = ((mode == MODE_FORWARD) && q_full) ||
                       (hdr_done && (bank_busy || q_full));
  assign accept = frame_valid && !frame_stall;

  assign is_echo = (hdr_words[2][63:56] == IP_PROTO_ICMP) &&
                   (frame_data[23:16] == ICMP_ECHO_REQUEST) &&
                   (frame_data[31:24] == ICMP_CODE_ECHO);

  // Reply header words, built from the held words and the fifth word.
  always_comb begin
    logic [63:0] w0, w1, w2, w3, w4;
    logic [15:0] ip_old, ip_new, ic_old, ic_new, ipc, icc;
    w0 = hdr_words[0];
    w1 = hdr_words[1];
    w2 = hdr_words[2];
    w3 = hdr_words[3];
    w4 = frame_data;
    ip_old = w2[63:48];
    ip_new = {ip_old[15:8], ttl};
    ipc    = csum_update(w3[15:0], ip_old, ip_new);
    ic_old = w4[31:16];
    ic_new = {ic_old[15:8], ICMP_ECHO_REPLY};
    icc    = csum_update(w4[47:32], ic_old, ic_new);

    bank_load.load    = 1'b0;
    bank_load.data[0] = {w0[15:0], w1[31:0], w0[63:48]};
    bank_load.data[1] = {w1[63:32], w0[47:16]};
    bank_load.data[2] = {ip_new, w2[47:0]};
    bank_load.data[3] = {w3[31:16], w4[15:0], w3[63:48], ipc};
    bank_load.data[4] = {w4[63:48], icc, ic_new, w3[47:32]};
    bank_load.be[0]   = ALL_BYTES;
    bank_load.be[1]   = hdr_be1;
    bank_load.be[2]   = hdr_be2;
    bank_load.be[3]   = ALL_BYTES;
    bank_load.be[4]   = byte_enable;

    mode_next      = mode;
    pos_next       = pos;
    q_push         = 1'b0;
    q_entry.is_hdr = 1'b0;
    q_entry.data   = frame_data;
    q_entry.be     = byte_enable;
    q_entry.last   = last_word;

    if (accept) begin
      unique case (mode)
        MODE_FORWARD: begin
          q_push = 1'b1;
          if (last_word) begin
            mode_next = MODE_COLLECT;
          end
        end
        MODE_DROP: begin
          if (last_word) begin
            mode_next = MODE_COLLECT;
          end
        end
        default: begin
          mode_next = MODE_COLLECT;
          if (last_word) begin
            // A frame that ends inside the header is dropped.
            pos_next = '0;
          end else if (pos_eff != HDR_LAST_IDX) begin
            pos_next = pos_eff + 1'b1;
          end else begin
            pos_next = '0;
            if (is_echo) begin
              bank_load.load = 1'b1;
              q_push         = 1'b1;
              q_entry.is_hdr = 1'b1;
              mode_next      = MODE_FORWARD;
            end else begin
              mode_next = MODE_DROP;
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept && collecting && (pos_eff != HDR_LAST_IDX)) begin
      hdr_words[pos_eff[1:0]] <= frame_data;
      if (pos_eff == 3'd1) begin
        hdr_be1 <= byte_enable;
      end
      if (pos_eff == 3'd2) begin
        hdr_be2 <= byte_enable;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_COLLECT;
      pos  <= '0;
      ttl  <= TTL_RESET;
    end else begin
      mode <= mode_next;
      pos  <= pos_next;
      if (cfg_valid && cfg_ready) begin
        ttl <= reply_ttl;
      end
    end
  end

endmodule

// ===== rtl/icmp_er_back.sv =====
// Back end: holds the reply header bank and drives the output register.
module icmp_er_back import icmp_er_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  bank_load_t  bank_load,
  output logic        bank_busy,
  input  q_entry_t    q_head,
  input  logic        q_empty,
  output logic        q_pop,
  output logic        reply_valid,
  input  logic        reply_stall,
  output logic [63:0] reply_data,
  output logic [7:0]  reply_byte_enable,
  output logic        reply_last
);

  logic [63:0]          bank_data [HDR_WORDS];
  logic [7:0]           bank_be   [HDR_WORDS];
  logic                 hdr_active;
  logic [HDR_IDX_W-1:0] hdr_cnt;
  logic                 adv;

  assign adv   = !reply_valid || !reply_stall;
  assign q_pop = adv && !hdr_active && !q_empty;

  always_ff @(posedge clk) begin
    if (bank_load.load) begin
      for (int i = 0; i < HDR_WORDS; i++) begin
        bank_data[i] <= bank_load.data[i];
        bank_be[i]   <= bank_load.be[i];
      end
    end
  end

  // A header marker emits bank word 0 at once; words 1 to 4 follow.
  always_ff @(posedge clk) begin
    if (adv) begin
      if (hdr_active) begin
        reply_data        <= bank_data[hdr_cnt];
        reply_byte_enable <= bank_be[hdr_cnt];
        reply_last        <= 1'b0;
      end else if (q_head.is_hdr) begin
        reply_data        <= bank_data[0];
        reply_byte_enable <= bank_be[0];
        reply_last        <= 1'b0;
      end else begin
        reply_data        <= q_head.data;
        reply_byte_enable <= q_head.be;
        reply_last        <= q_head.last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reply_valid <= 1'b0;
      hdr_active  <= 1'b0;
      hdr_cnt     <= '0;
      bank_busy   <= 1'b0;
    end else begin
      if (bank_load.load) begin
        bank_busy <= 1'b1;
      end
      if (adv) begin
        if (hdr_active) begin
          reply_valid <= 1'b1;
          if (hdr_cnt == HDR_LAST_IDX) begin
            hdr_active <= 1'b0;
            hdr_cnt    <= '0;
            bank_busy  <= 1'b0;
          end else begin
            hdr_cnt <= hdr_cnt + 1'b1;
          end
        end else if (!q_empty) begin
          reply_valid <= 1'b1;
          if (q_head.is_hdr) begin
            hdr_active <= 1'b1;
            hdr_cnt    <= 3'd1;
          end
        end else begin
          reply_valid <= 1'b0;
        end
      end
    end
  end

endmodule

// ===== rtl/icmp_echo_responder.sv =====
// Top level of the ICMP echo responder: front end, queue and back end.
//
//   channel   direction  handshake              carries
//   frame     in         frame_valid/stall      frame_data, byte_enable, last_word
//   reply     out        reply_valid/stall      reply_data, reply_byte_enable, reply_last
//   cfg       in         cfg_valid/cfg_ready    reply_ttl
//
// One frame word is taken per cycle unless the input stalls; the first four header
// words are held. The fifth word of an echo request loads the reply header into a bank,
// which leaves one word per cycle unless the output stalls. Later words follow through
// the queue. Reset is synchronous; it resets the frame mode and TTL and clears the
// queue and output valid. Input stalls on a forwarded or fifth header word while the
// queue is full, or on a fifth header word while the last reply header is unsent.
module icmp_echo_responder import icmp_er_pkg::*; #(
  parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        frame_valid,
  output logic        frame_stall,
  input  logic [63:0] frame_data,
  input  logic [7:0]  byte_enable,
  input  logic        last_word,
  output logic        reply_valid,
  input  logic        reply_stall,
  output logic [63:0] reply_data,
  output logic [7:0]  reply_byte_enable,
  output logic        reply_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  reply_ttl
);

  logic       q_push;
  q_entry_t   q_entry;
  logic       q_full;
  logic       q_pop;
  q_entry_t   q_head;
  logic       q_empty;
  bank_load_t bank_load;
  logic       bank_busy;

  icmp_er_front u_front (
    .clk         (clk),
    .rst         (rst),
    .frame_valid (frame_valid),
    .frame_stall (frame_stall),
    .frame_data  (frame_data),
    .byte_enable (byte_enable),
    .last_word   (last_word),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .reply_ttl   (reply_ttl),
    .q_push      (q_push),
    .q_entry     (q_entry),
    .q_full      (q_full),
    .bank_load   (bank_load),
    .bank_busy   (bank_busy)
  );

  icmp_er_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head       (q_head),
    .empty      (q_empty)
  );

  icmp_er_back u_back (
    .clk               (clk),
    .rst               (rst),
    .bank_load         (bank_load),
    .bank_busy         (bank_busy),
    .q_head            (q_head),
    .q_empty           (q_empty),
    .q_pop             (q_pop),
    .reply_valid       (reply_valid),
    .reply_stall       (reply_stall),
    .reply_data        (reply_data),
    .reply_byte_enable (reply_byte_enable),
    .reply_last        (reply_last)
  );

endmodule

// ===== test/icmp_echo_responder_test.sv =====
// Self-checking testbench for the ICMP echo responder: frame stimulus, reply checks, TTL writes.
module icmp_echo_responder_test import icmp_er_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LONG_HOLD_CYCLES = 400;
  localparam int unsigned WATCHDOG_LIMIT   = 3000;
  localparam int unsigned SETTLE_CYCLES    = 16;
  localparam int unsigned PHASE_WORDS      = 64;
  localparam int unsigned MAX_REPORTS      = 20;

  typedef enum int {FR_ECHO, FR_BAD_PROTO, FR_BAD_TYPE, FR_BAD_CODE} frame_kind_t;
  typedef enum int {FILL_RANDOM, FILL_ONES, FILL_ZEROS} fill_t;
  typedef enum int {SINK_OPEN, SINK_LIGHT, SINK_HEAVY, SINK_ALTERNATE} sink_pattern_t;

  typedef struct packed {
    logic [63:0] data;
    logic [7:0]  be;
    logic        last;
  } reply_word_t;

  // Tracks the responder's header state and holds the reply words still due.
  class echo_scoreboard;
    bit [63:0]   hdr_word[HDR_WORDS];
    bit [7:0]    hdr_en[HDR_WORDS];
    bit [2:0]    hdr_pos;
    bit [1:0]    mode;
    bit [7:0]    ttl;
    reply_word_t replies_due[$];
    int unsigned mismatches;
    int unsigned words_taken;
    int unsigned replies_checked;
    int unsigned echoes_answered;

    function new();
      ttl = TTL_RESET;
      mode = MODE_COLLECT;
      hdr_pos = '0;
    endfunction

    function void set_ttl(input bit [7:0] value);
      ttl = value;
    endfunction

    function int unsigned pending();
      return replies_due.size();
    endfunction

    function bit [15:0] ones_add(input bit [15:0] a, input bit [15:0] b);
      bit [16:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[15:0] + {15'd0, s[16]};
    endfunction

    function bit [15:0] patch_csum(input bit [15:0] hc, input bit [15:0] old_w,
                                   input bit [15:0] new_w);
      return ~ones_add(ones_add(~hc, ~old_w), new_w);
    endfunction

    function void push_reply(input bit [63:0] d, input bit [7:0] be, input bit last);
      reply_word_t r;
      r.data = d;
      r.be = be;
      r.last = last;
      replies_due.push_back(r);
    endfunction

    function void note_frame_word(input bit [63:0] d, input bit [7:0] be, input bit last);
      int unsigned p;
      bit [15:0] ip_old, ip_new, ic_old, ic_new, ip_sum, ic_sum;
      bit [63:0] w0, w1, w2, w3, w4;
      words_taken++;
      if (mode == MODE_FORWARD) begin
        push_reply(d, be, last);
        if (last) mode = MODE_COLLECT;
        return;
      end
      if (mode == MODE_DROP) begin
        if (last) mode = MODE_COLLECT;
        return;
      end
      p = (hdr_pos > HDR_LAST_IDX) ? 0 : hdr_pos;
      hdr_word[p] = d;
      hdr_en[p] = be;
      // A frame that ends inside the header is discarded silently.
      if (last) begin
        hdr_pos = '0;
        return;
      end
      if (p < HDR_LAST_IDX) begin
        hdr_pos = 3'(p + 1);
        return;
      end
      hdr_pos = '0;
      w0 = hdr_word[0];
      w1 = hdr_word[1];
      w2 = hdr_word[2];
      w3 = hdr_word[3];
      w4 = hdr_word[4];
      if (w2[63:56] != IP_PROTO_ICMP || w4[23:16] != ICMP_ECHO_REQUEST ||
          w4[31:24] != ICMP_CODE_ECHO) begin
        mode = MODE_DROP;
        return;
      end
      ip_old = w2[63:48];
      ip_new = {ip_old[15:8], ttl};
      ip_sum = patch_csum(w3[15:0], ip_old, ip_new);
      ic_old = w4[31:16];
      ic_new = {ic_old[15:8], ICMP_ECHO_REPLY};
      ic_sum = patch_csum(w4[47:32], ic_old, ic_new);
      push_reply({w0[15:0], w1[31:0], w0[63:48]}, ALL_BYTES, 1'b0);
      push_reply({w1[63:32], w0[47:16]}, hdr_en[1], 1'b0);
      push_reply({ip_new, w2[47:0]}, hdr_en[2], 1'b0);
      push_reply({w3[31:16], w4[15:0], w3[63:48], ip_sum}, ALL_BYTES, 1'b0);
      push_reply({w4[63:48], ic_sum, ic_new, w3[47:32]}, hdr_en[4], 1'b0);
      echoes_answered++;
      mode = MODE_FORWARD;
    endfunction

    function void check_reply(input logic [63:0] d, input logic [7:0] be, input logic last);
      reply_word_t want;
      bit bad;
      if (replies_due.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: reply word %h arrived with nothing expected", $time, d);
        return;
      end
      want = replies_due.pop_front();
      replies_checked++;
      bad = (d !== want.data) || (be !== want.be) || (last !== want.last);
      if (!bad) return;
      mismatches++;
      if (mismatches > MAX_REPORTS) return;
      if (d !== want.data)
        $display("%0t: reply_data expected %h, got %h", $time, want.data, d);
      if (be !== want.be)
        $display("%0t: reply_byte_enable expected %h, got %h", $time, want.be, be);
      if (last !== want.last)
        $display("%0t: reply_last expected %b, got %b", $time, want.last, last);
    endfunction
  endclass

  logic        clk;
  logic        rst = 1'b1;
  logic        frame_valid = 1'b0;
  logic        frame_stall;
  logic [63:0] frame_data = '0;
  logic [7:0]  byte_enable = '0;
  logic        last_word = 1'b0;
  logic        reply_valid;
  logic        reply_stall = 1'b0;
  logic [63:0] reply_data;
  logic [7:0]  reply_byte_enable;
  logic        reply_last;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  reply_ttl = TTL_RESET;

  echo_scoreboard sb;
  bit          offering = 1'b0;
  bit          steady_flow = 1'b0;
  bit          long_hold_req = 1'b0;
  int unsigned burst_left = 0;
  int unsigned quiet_cycles = 0;

  icmp_echo_responder u_dut (
    .clk               (clk),
    .rst               (rst),
    .frame_valid       (frame_valid),
    .frame_stall       (frame_stall),
    .frame_data        (frame_data),
    .byte_enable       (byte_enable),
    .last_word         (last_word),
    .reply_valid       (reply_valid),
    .reply_stall       (reply_stall),
    .reply_data        (reply_data),
    .reply_byte_enable (reply_byte_enable),
    .reply_last        (reply_last),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .reply_ttl         (reply_ttl)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (frame_valid && !frame_stall) sb.note_frame_word(frame_data, byte_enable, last_word);
      if (reply_valid && !reply_stall) sb.check_reply(reply_data, reply_byte_enable, reply_last);
    end
  end

  always @(posedge clk) begin
    if (rst || (frame_valid && !frame_stall) || (reply_valid && !reply_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Reply side: a randomly chosen stall pattern, with one long hold on request.
  initial begin : reply_sink
    int unsigned cyc;
    sink_pattern_t pattern;
    cyc = 0;
    pattern = SINK_OPEN;
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc % 64 == 0) pattern = sink_pattern_t'($urandom_range(0, 3));
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        reply_stall <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
      end else begin
        case (pattern)
          SINK_OPEN:  reply_stall <= 1'b0;
          SINK_LIGHT: reply_stall <= ($urandom_range(0, 9) < 3);
          SINK_HEAVY: reply_stall <= ($urandom_range(0, 9) < 7);
          default:    reply_stall <= cyc[0];
        endcase
      end
    end
  end

  task automatic stop_offering();
    if (offering) begin
      frame_valid <= 1'b0;
      offering = 1'b0;
    end
  endtask

  task automatic send_word(input bit [63:0] d, input bit [7:0] be, input bit last);
    frame_valid <= 1'b1;
    frame_data <= d;
    byte_enable <= be;
    last_word <= last;
    offering = 1'b1;
    do @(posedge clk); while (!(frame_valid && !frame_stall));
  endtask

  // Bursts of random length with random gaps, unless the phase runs back to back.
  task automatic pace_sender();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      if (!steady_flow) begin
        stop_offering();
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
  endtask

  function automatic bit [7:0] other_than(input bit [7:0] good);
    bit [7:0] v;
    v = 8'($urandom);
    return (v == good) ? ~good : v;
  endfunction

  task automatic send_frame(input frame_kind_t kind, input int n_words, input fill_t fill);
    bit [63:0] w;
    bit [7:0]  en;
    for (int i = 0; i < n_words; i++) begin
      case (fill)
        FILL_ONES: begin
          w = '1;
          en = '1;
        end
        FILL_ZEROS: begin
          w = '0;
          en = '0;
        end
        default: begin
          w = {$urandom, $urandom};
          en = ($urandom_range(0, 3) == 0) ? 8'($urandom) : ALL_BYTES;
        end
      endcase
      if (i == 2) w[63:56] = (kind == FR_BAD_PROTO) ? other_than(IP_PROTO_ICMP) : IP_PROTO_ICMP;
      if (i == 4) begin
        w[23:16] = (kind == FR_BAD_TYPE) ? other_than(ICMP_ECHO_REQUEST) : ICMP_ECHO_REQUEST;
        w[31:24] = (kind == FR_BAD_CODE) ? other_than(ICMP_CODE_ECHO) : ICMP_CODE_ECHO;
      end
      send_word(w, en, i == n_words - 1);
      pace_sender();
    end
  endtask

  task automatic write_ttl(input bit [7:0] value);
    cfg_valid <= 1'b1;
    reply_ttl <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_ttl(value);
  endtask

  // The block may still be chewing on a dropped frame, so wait out a settle period after the replies drain.
  task automatic wait_drained();
    stop_offering();
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_random_phase(input int unsigned target, input bit steady, input bit hold);
    int unsigned echo_words;
    int unsigned r;
    int unsigned len;
    echo_words = 0;
    steady_flow = steady;
    while (echo_words < target) begin
      if (hold && echo_words > target / 3) begin
        long_hold_req = 1'b1;
        hold = 1'b0;
      end
      r = $urandom_range(0, 99);
      if (r < 70) begin
        len = ($urandom_range(0, 15) == 0) ? 6 + $urandom_range(0, 30) : 6 + $urandom_range(0, 6);
        send_frame(FR_ECHO, len, FILL_RANDOM);
        echo_words += len;
      end else if (r < 78) begin
        send_frame(FR_ECHO, $urandom_range(1, 5), FILL_RANDOM);
      end else if (r < 86) begin
        send_frame(FR_BAD_PROTO, $urandom_range(5, 10), FILL_RANDOM);
      end else if (r < 93) begin
        send_frame(FR_BAD_TYPE, $urandom_range(5, 10), FILL_RANDOM);
      end else begin
        send_frame(FR_BAD_CODE, $urandom_range(5, 10), FILL_RANDOM);
      end
    end
    steady_flow = 1'b0;
  endtask

  initial begin : stimulus
    sb = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed frames at the reset TTL: extreme data, header enables all off,
    // frames that end inside the header, and a request of the wrong type.
    send_frame(FR_ECHO, 6, FILL_ONES);
    send_frame(FR_ECHO, 6, FILL_ZEROS);
    send_frame(FR_ECHO, 1, FILL_RANDOM);
    send_frame(FR_ECHO, 5, FILL_RANDOM);
    send_frame(FR_BAD_TYPE, 6, FILL_RANDOM);
    wait_drained();

    write_ttl(8'h00);
    run_random_phase(PHASE_WORDS, 1'b0, 1'b0);
    wait_drained();
    write_ttl(8'hFF);
    run_random_phase(PHASE_WORDS, 1'b0, 1'b1);
    wait_drained();
    write_ttl(8'($urandom));
    run_random_phase(PHASE_WORDS, 1'b1, 1'b0);
    wait_drained();
    write_ttl(8'($urandom));
    run_random_phase(PHASE_WORDS, 1'b0, 1'b0);
    wait_drained();

    $display("Sent %0d frame words over five TTL settings (reset, 0, 255, two random).",
             sb.words_taken);
    $display("Answered %0d echo requests, checked %0d reply words, %0d mismatches.",
             sb.echoes_answered, sb.replies_checked, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/icmp_er_pkg.sv
rtl/icmp_er_fifo.sv
rtl/icmp_er_front.sv
rtl/icmp_er_back.sv
rtl/icmp_echo_responder.sv
test/icmp_echo_responder_test.sv
